// ----- hw/rtl/nearest_neighbor_zoom_scaler_defines.svh -----
// ----------------------------------------------------------------------------
// nearest neighbor zoom scaler defines
// assertion helpers shared by the scaler rtl
// ----------------------------------------------------------------------------
`ifndef NEAREST_NEIGHBOR_ZOOM_SCALER_DEFINES_SVH
`define NEAREST_NEIGHBOR_ZOOM_SCALER_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define NNZS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked while out of reset
`define NNZS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/nnzs_pkg.sv -----
// ----------------------------------------------------------------------------
// nnzs_pkg
// types and constants of the nearest neighbor zoom scaler
// ----------------------------------------------------------------------------
package nnzs_pkg;

  // source store geometry and coordinate range
  localparam int SRC_MAX_WIDTH  = 256;
  localparam int SRC_MAX_HEIGHT = 256;
  localparam int OUT_COORD_BITS = 10;

  // field widths
  localparam int POS_W   = 10;
  localparam int COLOR_W = 8;
  localparam int PIX_W   = 3 * COLOR_W;
  localparam int SCALE_W = 8;
  localparam int SIZE_W  = 9;
  localparam int ACT_W   = 2;

  // zoom is kept in tenths
  localparam int TENTHS = 10;

  // divider: numerator is coordinate times ten, a few quotient bits per stage
  localparam int NUM_W      = OUT_COORD_BITS + 4;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = (NUM_W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int NUM_PAD_W  = DIV_STAGES * DIV_STEPS;

  // store addressing
  localparam int STORE_DEPTH = SRC_MAX_WIDTH * SRC_MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // register port
  localparam int PADDR_W   = 5;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SCALE_MIN  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SCALE_MAX  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SCALE_STEP = 3'd4;

  // reset values
  localparam logic [SIZE_W-1:0]  SRC_WIDTH_RST  = 9'd256;
  localparam logic [SIZE_W-1:0]  SRC_HEIGHT_RST = 9'd256;
  localparam logic [SCALE_W-1:0] SCALE_MIN_RST  = 8'd1;
  localparam logic [SCALE_W-1:0] SCALE_MAX_RST  = 8'd20;
  localparam logic [SCALE_W-1:0] SCALE_STEP_RST = 8'd1;
  localparam logic [SCALE_W-1:0] SCALE_RST      = 8'd10;

  // color returned for a point off the source
  localparam logic [COLOR_W-1:0] OUTSIDE_RED   = 8'd0;
  localparam logic [COLOR_W-1:0] OUTSIDE_GREEN = 8'd0;
  localparam logic [COLOR_W-1:0] OUTSIDE_BLUE  = 8'd255;

  typedef enum logic [ACT_W-1:0] {
    ACT_WRITE  = 2'd0,
    ACT_SAMPLE = 2'd1,
    ACT_TICK   = 2'd2
  } action_e;

  typedef enum logic {
    KIND_WRITE  = 1'b0,
    KIND_SAMPLE = 1'b1
  } kind_e;

  // one lane of the restoring divider
  typedef struct packed {
    logic [NUM_PAD_W-1:0] num;
    logic [SCALE_W-1:0]   rem;
  } div_lane_t;

  // payload of a divider stage
  typedef struct packed {
    kind_e              kind;
    div_lane_t          lx;
    div_lane_t          ly;
    logic [SCALE_W-1:0] divisor;
    logic [ADDR_W-1:0]  waddr;
    logic [PIX_W-1:0]   wdata;
  } div_stage_t;

  // payload of the stage that drives the store
  typedef struct packed {
    kind_e             kind;
    logic              hit;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  wdata;
  } mem_stage_t;

endpackage

// ----- hw/rtl/nnzs_stream_if.sv -----
// ----------------------------------------------------------------------------
// nnzs stream interfaces
// valid/ready channels for scaler commands and sampled pixels
// ----------------------------------------------------------------------------
interface nnzs_in_if;
  import nnzs_pkg::*;

  logic               valid;
  logic               ready;
  logic [ACT_W-1:0]   action;
  logic [POS_W-1:0]   pos_x;
  logic [POS_W-1:0]   pos_y;
  logic [COLOR_W-1:0] in_red;
  logic [COLOR_W-1:0] in_green;
  logic [COLOR_W-1:0] in_blue;

  modport source (output valid, action, pos_x, pos_y, in_red, in_green, in_blue,
                  input ready);
  modport sink (input valid, action, pos_x, pos_y, in_red, in_green, in_blue,
                output ready);
endinterface

interface nnzs_out_if;
  import nnzs_pkg::*;

  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] out_red;
  logic [COLOR_W-1:0] out_green;
  logic [COLOR_W-1:0] out_blue;
  logic               outside;

  modport source (output valid, out_red, out_green, out_blue, outside, input ready);
  modport sink (input valid, out_red, out_green, out_blue, outside, output ready);
endinterface

// ----- hw/rtl/nnzs_ram.sv -----
// ----------------------------------------------------------------------------
// nnzs_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module nnzs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/nearest_neighbor_zoom_scaler.sv -----
// ----------------------------------------------------------------------------
// nearest_neighbor_zoom_scaler
// zooms a stored rgb source image by nearest neighbor sampling
// ----------------------------------------------------------------------------
// The block takes one transaction per clock and returns one sampled pixel per
// clock while the output side keeps up. A sample passes through one entry
// stage, DIV_STAGES stages of the two restoring dividers that form x*10/scale
// and y*10/scale (DIV_STEPS quotient bits per stage), one bounds and address
// stage and the registered read of the source store. Pixel writes pass through
// the same stages and reach the store in order with samples, so a sample always
// sees the writes accepted before it. Frame ticks update the zoom at accept
// time. A stalled output holds the whole pipeline. The store is not cleared:
// reading a pixel that was never written returns an undefined color.
// ----------------------------------------------------------------------------
`include "nearest_neighbor_zoom_scaler_defines.svh"

module nearest_neighbor_zoom_scaler (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  nnzs_in_if.sink                        in_i,
  nnzs_out_if.source                     out_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [nnzs_pkg::PADDR_W-1:0]   paddr,
  input  logic [nnzs_pkg::PDATA_W-1:0]   pwdata,
  output logic [nnzs_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);
  import nnzs_pkg::*;

  // restoring division, DIV_STEPS quotient bits shifted into num
  function automatic div_lane_t div_steps(div_lane_t lane, logic [SCALE_W-1:0] d);
    logic [SCALE_W:0] t;
    div_lane_t        r;
    r = lane;
    for (int i = 0; i < DIV_STEPS; i++) begin
      t     = {r.rem, r.num[NUM_PAD_W-1]};
      r.num = {r.num[NUM_PAD_W-2:0], 1'b0};
      if (t >= {1'b0, d}) begin
        t        = t - {1'b0, d};
        r.num[0] = 1'b1;
      end
      r.rem = t[SCALE_W-1:0];
    end
    return r;
  endfunction

  // configuration registers
  logic [SIZE_W-1:0]  src_width_q, src_height_q;
  logic [SCALE_W-1:0] scale_min_q, scale_max_q, scale_step_q;
  logic [REG_IDX_W-1:0] reg_idx;
  logic cfg_we;

  // zoom state
  logic [SCALE_W-1:0] scale_q, scale_d;
  logic               rising_q, rising_d;

  // pipeline
  logic       adv, in_acc;
  logic       div_vld_q [DIV_STAGES+1];
  div_stage_t div_q     [DIV_STAGES+1];
  div_stage_t entry_d;
  logic       entry_vld;
  logic       mem_vld_q;
  mem_stage_t mem_q, mem_d;
  logic       out_vld_q, out_outside_q;
  logic [PIX_W-1:0] rdata;
  logic       ram_we, ram_re;

  // apb register port
  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign cfg_we  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q  <= SRC_WIDTH_RST;
      src_height_q <= SRC_HEIGHT_RST;
      scale_min_q  <= SCALE_MIN_RST;
      scale_max_q  <= SCALE_MAX_RST;
      scale_step_q <= SCALE_STEP_RST;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_SRC_WIDTH:  src_width_q  <= pwdata[SIZE_W-1:0];
        REG_SRC_HEIGHT: src_height_q <= pwdata[SIZE_W-1:0];
        REG_SCALE_MIN:  scale_min_q  <= pwdata[SCALE_W-1:0];
        REG_SCALE_MAX:  scale_max_q  <= pwdata[SCALE_W-1:0];
        REG_SCALE_STEP: scale_step_q <= pwdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_idx)
      REG_SRC_WIDTH:  prdata = PDATA_W'(src_width_q);
      REG_SRC_HEIGHT: prdata = PDATA_W'(src_height_q);
      REG_SCALE_MIN:  prdata = PDATA_W'(scale_min_q);
      REG_SCALE_MAX:  prdata = PDATA_W'(scale_max_q);
      REG_SCALE_STEP: prdata = PDATA_W'(scale_step_q);
      default:        prdata = '0;
    endcase
  end

  // handshake: the pipeline moves unless a result waits at the output
  assign adv         = !out_vld_q || out_o.ready;
  assign in_i.ready  = adv;
  assign in_acc      = in_i.valid && adv;

  // frame tick: step, clamp at minimum, then at maximum, flipping direction
  always_comb begin
    logic signed [SCALE_W+1:0] s;
    logic signed [SCALE_W+1:0] lo;
    logic signed [SCALE_W+1:0] hi;
    logic                      dir;
    lo  = $signed({2'b00, scale_min_q});
    hi  = $signed({2'b00, scale_max_q});
    dir = rising_q;
    if (rising_q) begin
      s = $signed({2'b00, scale_q}) + $signed({2'b00, scale_step_q});
    end else begin
      s = $signed({2'b00, scale_q}) - $signed({2'b00, scale_step_q});
    end
    if (s < lo) begin
      s   = lo;
      dir = !dir;
    end
    if (s > hi) begin
      s   = hi;
      dir = !dir;
    end
    scale_d  = scale_q;
    rising_d = rising_q;
    if (in_acc && (in_i.action == ACT_TICK)) begin
      scale_d  = s[SCALE_W-1:0];
      rising_d = dir;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q  <= SCALE_RST;
      rising_q <= 1'b1;
    end else begin
      scale_q  <= scale_d;
      rising_q <= rising_d;
    end
  end

  // entry stage: numerators, divisor and write address
  always_comb begin
    logic [NUM_W-1:0] nx;
    logic [NUM_W-1:0] ny;
    logic             wr_ok;
    nx = NUM_W'(in_i.pos_x[OUT_COORD_BITS-1:0]) * NUM_W'(TENTHS);
    ny = NUM_W'(in_i.pos_y[OUT_COORD_BITS-1:0]) * NUM_W'(TENTHS);
    wr_ok = (32'(in_i.pos_x) < SRC_MAX_WIDTH) && (32'(in_i.pos_y) < SRC_MAX_HEIGHT);
    entry_d.lx.num  = NUM_PAD_W'(nx);
    entry_d.lx.rem  = '0;
    entry_d.ly.num  = NUM_PAD_W'(ny);
    entry_d.ly.rem  = '0;
    entry_d.divisor = (scale_q == '0) ? SCALE_W'(1) : scale_q;
    entry_d.waddr   = ADDR_W'(32'(in_i.pos_y) * SRC_MAX_WIDTH + 32'(in_i.pos_x));
    entry_d.wdata   = {in_i.in_red, in_i.in_green, in_i.in_blue};
    entry_d.kind    = KIND_SAMPLE;
    entry_vld       = 1'b0;
    unique case (in_i.action)
      ACT_WRITE: begin
        entry_d.kind = KIND_WRITE;
        entry_vld    = in_acc && wr_ok;
      end
      ACT_SAMPLE: begin
        entry_vld = in_acc;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_vld_q[0] <= 1'b0;
    end else if (adv) begin
      div_vld_q[0] <= entry_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      div_q[0] <= entry_d;
    end
  end

  // divider stages, both lanes in step
  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        div_vld_q[k] <= 1'b0;
      end else if (adv) begin
        div_vld_q[k] <= div_vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        div_q[k].kind    <= div_q[k-1].kind;
        div_q[k].lx      <= div_steps(div_q[k-1].lx, div_q[k-1].divisor);
        div_q[k].ly      <= div_steps(div_q[k-1].ly, div_q[k-1].divisor);
        div_q[k].divisor <= div_q[k-1].divisor;
        div_q[k].waddr   <= div_q[k-1].waddr;
        div_q[k].wdata   <= div_q[k-1].wdata;
      end
    end
  end

  // bounds check and store address
  always_comb begin
    logic [NUM_PAD_W-1:0] qx;
    logic [NUM_PAD_W-1:0] qy;
    logic                 in_x;
    logic                 in_y;
    qx   = div_q[DIV_STAGES].lx.num;
    qy   = div_q[DIV_STAGES].ly.num;
    in_x = (32'(qx) < 32'(src_width_q)) && (32'(qx) < SRC_MAX_WIDTH);
    in_y = (32'(qy) < 32'(src_height_q)) && (32'(qy) < SRC_MAX_HEIGHT);
    mem_d.kind   = div_q[DIV_STAGES].kind;
    mem_d.hit    = in_x && in_y;
    mem_d.wdata  = div_q[DIV_STAGES].wdata;
    if (div_q[DIV_STAGES].kind == KIND_WRITE) begin
      mem_d.addr = div_q[DIV_STAGES].waddr;
    end else begin
      mem_d.addr = ADDR_W'(32'(qy) * SRC_MAX_WIDTH + 32'(qx));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_vld_q <= 1'b0;
    end else if (adv) begin
      mem_vld_q <= div_vld_q[DIV_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mem_q <= mem_d;
    end
  end

  // source store access, writes and samples in transaction order
  assign ram_we = adv && mem_vld_q && (mem_q.kind == KIND_WRITE);
  assign ram_re = adv && mem_vld_q && (mem_q.kind == KIND_SAMPLE) && mem_q.hit;

  nnzs_ram #(
    .WIDTH (PIX_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (mem_q.addr),
    .wdata_i (mem_q.wdata),
    .re_i    (ram_re),
    .raddr_i (mem_q.addr),
    .rdata_o (rdata)
  );

  // output stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= mem_vld_q && (mem_q.kind == KIND_SAMPLE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_outside_q <= !mem_q.hit;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.outside   = out_outside_q;
  assign out_o.out_red   = out_outside_q ? OUTSIDE_RED   : rdata[PIX_W-1 -: COLOR_W];
  assign out_o.out_green = out_outside_q ? OUTSIDE_GREEN : rdata[2*COLOR_W-1 -: COLOR_W];
  assign out_o.out_blue  = out_outside_q ? OUTSIDE_BLUE  : rdata[COLOR_W-1:0];

  // checks
  `NNZS_ASSERT_IMP(a_div_nonzero, div_vld_q[0], div_q[0].divisor != '0, "zero divisor")
  `NNZS_ASSERT_IMP(a_rem_x_below, div_vld_q[DIV_STAGES], div_q[DIV_STAGES].lx.rem < div_q[DIV_STAGES].divisor, "x remainder not below divisor")
  `NNZS_ASSERT_IMP(a_rem_y_below, div_vld_q[DIV_STAGES], div_q[DIV_STAGES].ly.rem < div_q[DIV_STAGES].divisor, "y remainder not below divisor")
  `NNZS_ASSERT_NXT(a_stall_holds, !adv && mem_vld_q, mem_vld_q && $stable(mem_q), "store stage moved while stalled")
  `NNZS_ASSERT_IMP(a_out_from_sample, $rose(out_vld_q), $past(mem_vld_q && (mem_q.kind == KIND_SAMPLE)), "result without a sample")

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the nearest neighbor zoom scaler
// ----------------------------------------------------------------------------
// Drives commands on the input stream and register writes on the APB port.
// A scoreboard keeps its own image store, zoom state and register copies and
// works out the sampled pixel for every accepted sample. Each pixel on the
// output stream is compared field by field with the oldest expected one.
// A directed part covers the corner cases, then random phases with fresh
// register settings mix writes, samples, zoom ticks and dead commands while
// the stream sides idle at random in most phases. A sample whose source pixel was never
// written is preceded by a write to that pixel, so the store is never read
// where its contents are undefined.
// ----------------------------------------------------------------------------
module tb_top;
  import nnzs_pkg::*;

  // unused command code
  localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;

  localparam int NUM_PHASES      = 10;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int SETTLE_CYCLES   = 20;
  localparam int RX_HOLD_CYCLES  = 300;
  localparam int LIMIT_CYCLES    = 500000;
  localparam int MAX_PRINTED     = 100;

  typedef struct packed {
    logic [ACT_W-1:0]   action;
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } command_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               outside;
  } pixel_t;

  // shadow of the scaler: store, zoom state, registers and pending pixels
  class zoom_scoreboard;
    logic [PIX_W-1:0]   image_mem [STORE_DEPTH];
    bit                 written [STORE_DEPTH];
    logic [SIZE_W-1:0]  width_q;
    logic [SIZE_W-1:0]  height_q;
    logic [SCALE_W-1:0] min_q;
    logic [SCALE_W-1:0] max_q;
    logic [SCALE_W-1:0] step_q;
    logic [SCALE_W-1:0] scale_q;
    bit                 rising_q;
    pixel_t             pixel_q [$];
    int                 mismatches;
    int                 checked;
    int                 writes;
    int                 ticks;

    function new();
      width_q    = SRC_WIDTH_RST;
      height_q   = SRC_HEIGHT_RST;
      min_q      = SCALE_MIN_RST;
      max_q      = SCALE_MAX_RST;
      step_q     = SCALE_STEP_RST;
      scale_q    = SCALE_RST;
      rising_q   = 1'b1;
      mismatches = 0;
      checked    = 0;
      writes     = 0;
      ticks      = 0;
    endfunction

    function void set_reg(logic [REG_IDX_W-1:0] idx, logic [PDATA_W-1:0] val);
      case (idx)
        REG_SRC_WIDTH:  width_q  = val[SIZE_W-1:0];
        REG_SRC_HEIGHT: height_q = val[SIZE_W-1:0];
        REG_SCALE_MIN:  min_q    = val[SCALE_W-1:0];
        REG_SCALE_MAX:  max_q    = val[SCALE_W-1:0];
        REG_SCALE_STEP: step_q   = val[SCALE_W-1:0];
        default: ;
      endcase
    endfunction

    function int eff_width();
      return (int'(width_q) < SRC_MAX_WIDTH) ? int'(width_q) : SRC_MAX_WIDTH;
    endfunction

    function int eff_height();
      return (int'(height_q) < SRC_MAX_HEIGHT) ? int'(height_q) : SRC_MAX_HEIGHT;
    endfunction

    // output coordinate to source coordinate at the current zoom
    function void map_point(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                            output int sx, output int sy, output bit hit);
      int div;
      int cx;
      int cy;
      div = (scale_q == 0) ? 1 : int'(scale_q);
      cx  = int'(x) % (1 << OUT_COORD_BITS);
      cy  = int'(y) % (1 << OUT_COORD_BITS);
      sx  = (cx * TENTHS) / div;
      sy  = (cy * TENTHS) / div;
      hit = (sx < eff_width()) && (sy < eff_height());
    endfunction

    function bit is_written(int sx, int sy);
      return written[sy * SRC_MAX_WIDTH + sx];
    endfunction

    // zoom moves one step, min clamp first, then max clamp
    function void step_zoom();
      int s;
      s = rising_q ? int'(scale_q) + int'(step_q) : int'(scale_q) - int'(step_q);
      if (s < int'(min_q)) begin
        s = int'(min_q);
        rising_q = !rising_q;
      end
      if (s > int'(max_q)) begin
        s = int'(max_q);
        rising_q = !rising_q;
      end
      scale_q = s[SCALE_W-1:0];
    endfunction

    function void note_input(command_t cmd);
      int     sx;
      int     sy;
      bit     hit;
      pixel_t pix;
      case (cmd.action)
        ACT_WRITE: begin
          if (int'(cmd.pos_x) < SRC_MAX_WIDTH && int'(cmd.pos_y) < SRC_MAX_HEIGHT) begin
            sx = int'(cmd.pos_y) * SRC_MAX_WIDTH + int'(cmd.pos_x);
            image_mem[sx] = {cmd.red, cmd.green, cmd.blue};
            written[sx]   = 1'b1;
            writes++;
          end
        end
        ACT_SAMPLE: begin
          map_point(cmd.pos_x, cmd.pos_y, sx, sy, hit);
          if (hit) begin
            {pix.red, pix.green, pix.blue} = image_mem[sy * SRC_MAX_WIDTH + sx];
            pix.outside = 1'b0;
          end else begin
            pix.red     = OUTSIDE_RED;
            pix.green   = OUTSIDE_GREEN;
            pix.blue    = OUTSIDE_BLUE;
            pix.outside = 1'b1;
          end
          pixel_q.push_back(pix);
        end
        ACT_TICK: begin
          step_zoom();
          ticks++;
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      if (mismatches < MAX_PRINTED) $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_result(pixel_t got);
      pixel_t want;
      if (pixel_q.size() == 0) begin
        report($sformatf("pixel with nothing pending r=%0d g=%0d b=%0d outside=%0b",
                         got.red, got.green, got.blue, got.outside));
        return;
      end
      want = pixel_q.pop_front();
      checked++;
      if (got.red !== want.red)
        report($sformatf("out_red %0d, expected %0d", got.red, want.red));
      if (got.green !== want.green)
        report($sformatf("out_green %0d, expected %0d", got.green, want.green));
      if (got.blue !== want.blue)
        report($sformatf("out_blue %0d, expected %0d", got.blue, want.blue));
      if (got.outside !== want.outside)
        report($sformatf("outside %0b, expected %0b", got.outside, want.outside));
    endtask

    function int pending();
      return pixel_q.size();
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  nnzs_in_if  in_if ();
  nnzs_out_if out_if ();

  nearest_neighbor_zoom_scaler i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  zoom_scoreboard sb;
  bit             tx_idle;
  bit             rx_idle;
  bit             rx_hold_req;
  int             settings;
  pixel_t         seen_pixel;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // hard stop if the run hangs
  initial begin
    #(LIMIT_CYCLES * 10);
    $display("FAILURE");
    $finish;
  end

  // gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return $urandom_range(12, 48);
    if (r < 8) return $urandom_range(1, 3);
    return 0;
  endfunction

  // offer one transaction and wait for it to be taken
  task automatic send_item(input command_t cmd);
    int gap;
    in_if.valid    <= 1'b1;
    in_if.action   <= cmd.action;
    in_if.pos_x    <= cmd.pos_x;
    in_if.pos_y    <= cmd.pos_y;
    in_if.in_red   <= cmd.red;
    in_if.in_green <= cmd.green;
    in_if.in_blue  <= cmd.blue;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_input(cmd);
    gap = tx_idle ? pick_gap() : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_action(input logic [ACT_W-1:0] act, input logic [POS_W-1:0] x,
                             input logic [POS_W-1:0] y);
    command_t cmd;
    cmd.action = act;
    cmd.pos_x  = x;
    cmd.pos_y  = y;
    cmd.red    = COLOR_W'($urandom_range(0, 255));
    cmd.green  = COLOR_W'($urandom_range(0, 255));
    cmd.blue   = COLOR_W'($urandom_range(0, 255));
    send_item(cmd);
  endtask

  task automatic write_pixel(input int x, input int y, input logic [COLOR_W-1:0] r,
                             input logic [COLOR_W-1:0] g, input logic [COLOR_W-1:0] b);
    command_t cmd;
    cmd.action = ACT_WRITE;
    cmd.pos_x  = x[POS_W-1:0];
    cmd.pos_y  = y[POS_W-1:0];
    cmd.red    = r;
    cmd.green  = g;
    cmd.blue   = b;
    send_item(cmd);
  endtask

  // sample, loading the source pixel first if it was never written
  task automatic sample_at(input int x, input int y);
    int sx;
    int sy;
    bit hit;
    sb.map_point(x[POS_W-1:0], y[POS_W-1:0], sx, sy, hit);
    if (hit && !sb.is_written(sx, sy))
      write_pixel(sx, sy, COLOR_W'($urandom_range(0, 255)), COLOR_W'($urandom_range(0, 255)),
                  COLOR_W'($urandom_range(0, 255)));
    send_action(ACT_SAMPLE, x[POS_W-1:0], y[POS_W-1:0]);
  endtask

  // register write: setup cycle, then access cycle
  task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input int val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= PDATA_W'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.set_reg(idx, PDATA_W'(val));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // stop sending, wait for every pixel and let writes and ticks settle
  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic configure(input int w, input int h, input int lo, input int hi,
                           input int st);
    drain();
    apb_write(REG_SRC_WIDTH, w);
    apb_write(REG_SRC_HEIGHT, h);
    apb_write(REG_SCALE_MIN, lo);
    apb_write(REG_SCALE_MAX, hi);
    apb_write(REG_SCALE_STEP, st);
    settings++;
  endtask

  function automatic int pick_size();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return $urandom_range(1, 24);
    if (r < 9) return $urandom_range(25, 256);
    return $urandom_range(257, 511);
  endfunction

  // coordinate near the zoomed image most of the time
  function automatic int pick_coord(input int size);
    int span;
    span = (size * ((sb.scale_q == 0) ? 1 : int'(sb.scale_q))) / TENTHS + 2;
    if (span > 1023) span = 1023;
    if ($urandom_range(0, 9) < 7) return $urandom_range(0, span);
    return $urandom_range(0, 1023);
  endfunction

  task automatic random_write();
    int r;
    int x;
    int y;
    r = $urandom_range(0, 19);
    if (r < 14) begin
      x = $urandom_range(0, sb.eff_width() - 1);
      y = $urandom_range(0, sb.eff_height() - 1);
    end else if (r < 17) begin
      x = $urandom_range(0, SRC_MAX_WIDTH - 1);
      y = $urandom_range(0, SRC_MAX_HEIGHT - 1);
    end else begin
      x = $urandom_range(0, 1023);
      y = $urandom_range(0, 1023);
    end
    write_pixel(x, y, COLOR_W'($urandom_range(0, 255)), COLOR_W'($urandom_range(0, 255)),
                COLOR_W'($urandom_range(0, 255)));
  endtask

  task automatic random_setup(input int phase);
    int lo;
    int hi;
    int st;
    case (phase)
      0: configure(1, 1, 1, 255, 255);
      1: configure(511, 511, 255, 255, 1);
      2: configure(256, 256, 1, 20, 1);
      default: begin
        lo = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 30);
        hi = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 255) : $urandom_range(lo, 255);
        st = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 10);
        configure(pick_size(), pick_size(), lo, hi, st);
      end
    endcase
  endtask

  // output side: random ready bursts, plus one long hold on request
  initial begin
    int burst;
    int gap;
    out_if.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (rx_hold_req) begin
        out_if.ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk_i);
        rx_hold_req = 1'b0;
      end
      burst = $urandom_range(1, 8);
      out_if.ready <= 1'b1;
      repeat (burst) @(posedge clk_i);
      gap = rx_idle ? pick_gap() : 0;
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      seen_pixel.red     = out_if.out_red;
      seen_pixel.green   = out_if.out_green;
      seen_pixel.blue    = out_if.out_blue;
      seen_pixel.outside = out_if.outside;
      sb.check_result(seen_pixel);
    end
  end

  // main sequence
  initial begin
    sb          = new();
    settings    = 0;
    tx_idle     = 1'b1;
    rx_idle     = 1'b1;
    rx_hold_req = 1'b0;
    rst_ni         <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    in_if.valid    <= 1'b0;
    in_if.action   <= ACT_WRITE;
    in_if.pos_x    <= '0;
    in_if.pos_y    <= '0;
    in_if.in_red   <= '0;
    in_if.in_green <= '0;
    in_if.in_blue  <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corners of the store, ignored writes, dead command, edge samples
    write_pixel(0, 0, 8'h00, 8'h00, 8'h00);
    write_pixel(255, 255, 8'hff, 8'hff, 8'hff);
    write_pixel(255, 0, 8'ha5, 8'h5a, 8'h3c);
    write_pixel(256, 0, 8'h12, 8'h34, 8'h56);
    write_pixel(0, 1023, 8'hff, 8'hff, 8'hff);
    send_action(ACT_NONE, 10'h3ff, 10'h3ff);
    sample_at(0, 0);
    sample_at(255, 255);
    sample_at(255, 0);
    sample_at(256, 0);
    sample_at(1023, 1023);
    send_action(ACT_TICK, 10'h3ff, 10'h000);
    sample_at(100, 100);

    // zero width: every sample falls outside
    drain();
    apb_write(REG_SRC_WIDTH, 0);
    sample_at(0, 0);

    // zoom bounces off the maximum and then falls to a zero scale
    configure(256, 1, 0, 20, 10);
    send_action(ACT_TICK, 10'h000, 10'h3ff);
    send_action(ACT_TICK, 10'h155, 10'h2aa);
    send_action(ACT_TICK, 10'h2aa, 10'h155);
    sample_at(25, 0);
    sample_at(0, 1);

    // minimum above maximum: both clamps fire in order
    configure(256, 1, 50, 30, 1);
    send_action(ACT_TICK, 10'h000, 10'h000);
    sample_at(3, 3);

    // oversized registers and the largest zoom
    configure(511, 300, 255, 255, 255);
    send_action(ACT_TICK, 10'h3ff, 10'h3ff);
    sample_at(1023, 1023);

    // random phases with fresh register settings
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      random_setup(phase);
      tx_idle = (phase % 4) != 1;
      rx_idle = (phase % 4) != 2;
      if (phase == 3) begin
        // output held off while the input keeps offering samples
        tx_idle     = 1'b0;
        rx_hold_req = 1'b1;
        repeat (60) sample_at(pick_coord(sb.eff_width()), pick_coord(sb.eff_height()));
        in_if.valid <= 1'b0;
        while (rx_hold_req) @(posedge clk_i);
        tx_idle = 1'b1;
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 34)
          random_write();
        else if (pick < 86)
          sample_at(pick_coord(sb.eff_width()), pick_coord(sb.eff_height()));
        else if (pick < 96)
          send_action(ACT_TICK, POS_W'($urandom_range(0, 1023)),
                      POS_W'($urandom_range(0, 1023)));
        else
          send_action(ACT_NONE, POS_W'($urandom_range(0, 1023)),
                      POS_W'($urandom_range(0, 1023)));
        if (n == ITEMS_PER_PHASE / 2 && phase == 5) drain();
      end
    end

    drain();
    $display("checked %0d sampled pixels against %0d pixel writes and %0d zoom ticks",
             sb.checked, sb.writes, sb.ticks);
    $display("went through %0d register settings, %0d mismatches", settings, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
